[hw/rtl/sis_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants of the stable index sorter
// Field widths, default sizes, the control bundle for the cell chain and
// the state encoding of the sequencer.
// ----------------------------------------------------------------------------
package sis_pkg;

    // Fixed widths of the channel fields.
    localparam int KEY_W = 32;
    localparam int IDX_W = 5;

    // Default sizes.
    localparam int MAX_ITEMS_DEF = 32;
    localparam int KEY_BITS_DEF  = 32;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic load;   // insert the broadcast key
        logic shift;  // move every entry one cell toward the head
    } chain_ctrl_t;

    // Sequencer states: collect keys, then hand out the sorted set.
    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } sis_state_t;

endpackage

[hw/rtl/sis_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_cell: one cell of the sorting chain
// Holds one key with its arrival position. On a load it keeps its entry,
// takes the new key, or takes its left neighbor's entry; on a shift it
// takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module sis_cell
    import sis_pkg::*;
#(
    parameter int CELL_W = KEY_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_ctrl_t       ctrl,
    input  logic [CELL_W-1:0] new_key,
    input  logic [IDX_W-1:0]  new_idx,
    input  logic              left_gt,
    input  logic [CELL_W-1:0] left_key,
    input  logic [IDX_W-1:0]  left_idx,
    input  logic              left_valid,
    input  logic [CELL_W-1:0] right_key,
    input  logic [IDX_W-1:0]  right_idx,
    input  logic              right_valid,
    output logic              gt,
    output logic [CELL_W-1:0] key,
    output logic [IDX_W-1:0]  idx,
    output logic              valid
);

    logic [CELL_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;

    // An empty cell counts as holding a key above every other key, so the
    // new key lands after all stored keys that are less than or equal to it.
    assign gt = !valid_reg || (key_reg > new_key);

    // Next entry of the cell.
    always_comb begin
        key_next   = key_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (ctrl.shift) begin
            key_next   = right_key;
            idx_next   = right_idx;
            valid_next = right_valid;
        end else if (ctrl.load && gt) begin
            if (left_gt) begin
                key_next   = left_key;
                idx_next   = left_idx;
                valid_next = left_valid;
            end else begin
                key_next   = new_key;
                idx_next   = new_idx;
                valid_next = 1'b1;
            end
        end
    end

    // The occupancy bit is cleared by reset; the payload needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

    assign key   = key_reg;
    assign idx   = idx_reg;
    assign valid = valid_reg;

endmodule

[hw/rtl/sis_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sis_chain: row of sorting cells
// Keeps the stored keys in ascending order, head first. Each cell talks only
// to its two neighbors; the first two cells feed the result channel.
// ----------------------------------------------------------------------------
module sis_chain
    import sis_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int CELL_W    = KEY_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  chain_ctrl_t       ctrl,
    input  logic [CELL_W-1:0] new_key,
    input  logic [IDX_W-1:0]  new_idx,
    output logic [CELL_W-1:0] head_key,
    output logic [IDX_W-1:0]  head_idx,
    output logic              head_last
);

    logic [CELL_W-1:0] key_w   [MAX_ITEMS];
    logic [IDX_W-1:0]  idx_w   [MAX_ITEMS];
    logic              valid_w [MAX_ITEMS];
    logic              gt_w    [MAX_ITEMS];

    // Build the row; the ends see an empty, non-greater neighbor.
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic              l_gt;
        logic [CELL_W-1:0] l_key;
        logic [IDX_W-1:0]  l_idx;
        logic              l_valid;
        logic [CELL_W-1:0] r_key;
        logic [IDX_W-1:0]  r_idx;
        logic              r_valid;

        if (i == 0) begin : g_head
            assign l_gt    = 1'b0;
            assign l_key   = '0;
            assign l_idx   = '0;
            assign l_valid = 1'b0;
        end else begin : g_mid
            assign l_gt    = gt_w[i-1];
            assign l_key   = key_w[i-1];
            assign l_idx   = idx_w[i-1];
            assign l_valid = valid_w[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign r_key   = '0;
            assign r_idx   = '0;
            assign r_valid = 1'b0;
        end else begin : g_body
            assign r_key   = key_w[i+1];
            assign r_idx   = idx_w[i+1];
            assign r_valid = valid_w[i+1];
        end

        sis_cell #(
            .CELL_W(CELL_W)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_key    (new_key),
            .new_idx    (new_idx),
            .left_gt    (l_gt),
            .left_key   (l_key),
            .left_idx   (l_idx),
            .left_valid (l_valid),
            .right_key  (r_key),
            .right_idx  (r_idx),
            .right_valid(r_valid),
            .gt         (gt_w[i]),
            .key        (key_w[i]),
            .idx        (idx_w[i]),
            .valid      (valid_w[i])
        );
    end

    // The head entry is the last of the set when the cell behind it is empty.
    assign head_key  = key_w[0];
    assign head_idx  = idx_w[0];
    assign head_last = !valid_w[1];

endmodule

[hw/rtl/stable_index_insertion_sort.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_index_insertion_sort: streaming stable argsort of a key set
// Collects up to MAX_ITEMS keys in a sorted cell chain and hands out their
// arrival positions in ascending key order, equal keys in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one key per transfer; s_final_key closes the set.
//   A key is taken every cycle while the set is open: each transfer inserts
//   the key into the chain of cells, all cells comparing at once.
//   A set also closes when its MAX_ITEMS-th key arrives without the final
//   mark; all of its results then carry m_truncated.
//   Result channel (m_*): once a set closes, one result per key leaves from
//   the head cell, smallest key first, the chain shifting one cell toward the
//   head on each result transfer; m_end_of_run marks the last one.
//   The first result is valid in the cycle after the closing key is taken.
//   s_ready is low while the set drains, so keys of the next set wait until
//   the last result of the set has left the head cell.
//   A stalled receiver holds the head entry and stops the chain in place.
//   Reset empties every cell and opens a new, empty set.
// ----------------------------------------------------------------------------
module stable_index_insertion_sort
    import sis_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF,
    parameter int KEY_BITS  = KEY_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [KEY_W-1:0] s_key,
    input  logic             s_final_key,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [IDX_W-1:0] m_orig_index,
    output logic [KEY_W-1:0] m_sorted_key,
    output logic             m_truncated,
    output logic             m_end_of_run
);

    // Stored key width: key bits above KEY_BITS are ignored.
    localparam int CELL_W = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CNT_W  = $clog2(MAX_ITEMS);

    sis_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              trunc_reg, trunc_next;
    chain_ctrl_t       ctrl;
    logic              at_cap;
    logic [CELL_W-1:0] head_key;
    logic [IDX_W-1:0]  head_idx;
    logic              head_last;

    assign at_cap = (cnt_reg == CNT_W'(MAX_ITEMS - 1));

    // Sequencer: collect the set, then drain it from the head cell.
    // Each state raises only its own ready or valid, so the other side's
    // handshake signal alone marks a transfer there.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        trunc_next = trunc_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        ctrl.load  = 1'b0;
        ctrl.shift = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready   = 1'b1;
                ctrl.load = s_valid;
                if (s_valid) begin
                    if (s_final_key || at_cap) begin
                        state_next = ST_DRAIN;
                        trunc_next = !s_final_key;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                m_valid    = 1'b1;
                ctrl.shift = m_ready;
                if (m_ready && head_last) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            trunc_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            trunc_reg <= trunc_next;
        end
    end

    // Sorted row of cells.
    sis_chain #(
        .MAX_ITEMS(MAX_ITEMS),
        .CELL_W   (CELL_W)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .new_key  (s_key[CELL_W-1:0]),
        .new_idx  (IDX_W'(cnt_reg)),
        .head_key (head_key),
        .head_idx (head_idx),
        .head_last(head_last)
    );

    // Index and key come straight from the head cell's registers, the end mark from the second cell's occupancy bit.
    assign m_orig_index = head_idx;
    assign m_sorted_key = KEY_W'(head_key);
    assign m_truncated  = trunc_reg;
    assign m_end_of_run = head_last;

endmodule

[test/tb_stable_index_insertion_sort.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_index_insertion_sort: self-checking bench for the stable key sorter
// Streams key sets into the sorter and rebuilds each sorted set in a small
// scoreboard. Every result transfer is compared field by field with the
// oldest predicted rank. The sets cover single keys, ties, extreme keys, sets
// closed at capacity with and without the last mark, and random sets. Both
// channels idle at random, and one long receiver stall backs up the input.
// ----------------------------------------------------------------------------
module tb_stable_index_insertion_sort
    import sis_pkg::*;
();

    localparam int N_CELLS      = MAX_ITEMS_DEF;
    localparam int SORT_BITS    = KEY_BITS_DEF;
    localparam int KEPT_BITS    = (SORT_BITS < KEY_W) ? SORT_BITS : KEY_W;
    localparam logic [KEY_W-1:0] SORT_MASK = {KEY_W{1'b1}} >> (KEY_W - KEPT_BITS);
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_START   = 300;
    localparam int HOLD_LEN     = 500;
    localparam int SETTLE_CYCLES = 50;
    localparam int LIMIT_CYCLES = 200000;
    localparam int N_DIRECTED   = 19;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [KEY_W-1:0] s_key;
    logic             s_final_key;
    logic             m_valid;
    logic             m_ready;
    logic [IDX_W-1:0] m_orig_index;
    logic [KEY_W-1:0] m_sorted_key;
    logic             m_truncated;
    logic             m_end_of_run;

    // One entry of a sorted set as it should leave the block.
    typedef struct {
        logic [IDX_W-1:0] orig_index;
        logic [KEY_W-1:0] sorted_key;
        logic             truncated;
        logic             end_of_run;
    } rank_t;

    // Tracks the open set in sorted order and the ranks still owed.
    class sort_scoreboard;
        logic [KEY_W-1:0] chain_key [N_CELLS];
        logic [IDX_W-1:0] chain_pos [N_CELLS];
        int               fill;
        rank_t            owed_ranks [$];
        int               error_count;

        function new();
            fill        = 0;
            error_count = 0;
        endfunction

        // Insert an accepted key after every stored key that is not larger.
        function void note_key(logic [KEY_W-1:0] key, logic last);
            logic [KEY_W-1:0] k;
            int               slot;
            rank_t            r;
            k    = key & SORT_MASK;
            slot = 0;
            while (slot < fill && chain_key[slot] <= k) slot++;
            for (int i = fill; i > slot; i--) begin
                chain_key[i] = chain_key[i-1];
                chain_pos[i] = chain_pos[i-1];
            end
            chain_key[slot] = k;
            chain_pos[slot] = IDX_W'(fill);
            fill++;
            // The set closes on the last mark or when the chain is full.
            if (last || fill == N_CELLS) begin
                for (int j = 0; j < fill; j++) begin
                    r.orig_index = chain_pos[j];
                    r.sorted_key = chain_key[j];
                    r.truncated  = !last;
                    r.end_of_run = (j == fill - 1);
                    owed_ranks = {owed_ranks, r};
                end
                fill = 0;
            end
        endfunction

        // Compare one result transfer with the oldest owed rank.
        function void check_result(logic [IDX_W-1:0] idx, logic [KEY_W-1:0] key,
                                   logic trunc, logic eor);
            rank_t want;
            if (owed_ranks.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: index %0d key %h trunc %b last %b",
                         $time, idx, key, trunc, eor);
                return;
            end
            want = owed_ranks.pop_front();
            if (want.orig_index !== idx || want.sorted_key !== key ||
                want.truncated !== trunc || want.end_of_run !== eor) begin
                error_count++;
                $display({"%0t: mismatch: expected index %0d key %h trunc %b last %b,",
                          " got index %0d key %h trunc %b last %b"},
                         $time, want.orig_index, want.sorted_key, want.truncated,
                         want.end_of_run, idx, key, trunc, eor);
            end
        endfunction
    endclass

    sort_scoreboard board;

    // Directed sets: single keys, ties, extremes and alternating bit patterns.
    logic [KEY_W-1:0] dir_keys [N_DIRECTED] = '{
        32'h0000_0000,
        32'hFFFF_FFFF,
        32'h0000_0005, 32'h0000_0005, 32'h0000_0005,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000,
        32'h0000_0007, 32'h0000_0003, 32'h0000_0007, 32'h0000_0000,
        32'h0000_0003, 32'hFFFF_FFFF, 32'h0000_0007,
        32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA
    };
    bit dir_last [N_DIRECTED] = '{
        1'b1,
        1'b1,
        1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b1
    };

    stable_index_insertion_sort #(
        .MAX_ITEMS (N_CELLS),
        .KEY_BITS  (SORT_BITS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key        (s_key),
        .s_final_key  (s_final_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_orig_index (m_orig_index),
        .m_sorted_key (m_sorted_key),
        .m_truncated  (m_truncated),
        .m_end_of_run (m_end_of_run)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Gap length between input transfers: mostly none, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Stall length of the receiver between ready stretches.
    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Offer one key from a falling edge and hold it until the transfer.
    task automatic send_key(input logic [KEY_W-1:0] key, input bit last, input int gap);
        s_valid     <= 1'b1;
        s_key       <= key;
        s_final_key <= last;
        do @(posedge aclk); while (!s_ready);
        board.note_key(key, last);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Send a set of random keys; style selects wide, tie-heavy or extreme keys.
    task automatic send_random_set(input int len, input bit marked, input int style,
                                   input bit dense);
        logic [KEY_W-1:0] key;
        for (int i = 0; i < len; i++) begin
            case (style)
                0: key = $urandom;
                1: key = $urandom_range(0, 3);
                default: begin
                    case ($urandom_range(0, 2))
                        0: key = '0;
                        1: key = '1;
                        default: key = $urandom;
                    endcase
                end
            endcase
            send_key(key, marked && (i == len - 1), dense ? 0 : pick_gap());
        end
    endtask

    // Receiver ready pattern, with one long hold counted from the start.
    initial begin : result_ready_gen
        int rx_cycle;
        int ready_left;
        int stall_left;
        m_ready    = 1'b0;
        rx_cycle   = 0;
        ready_left = 0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (stall_left == 0 && ready_left == 0) begin
                ready_left = $urandom_range(1, 40);
                stall_left = pick_stall();
            end
            if (rx_cycle == HOLD_START) stall_left = HOLD_LEN;
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                ready_left--;
            end
        end
    end

    // Check every result transfer against the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_orig_index, m_sorted_key, m_truncated, m_end_of_run);
        end
    end

    // Watchdog on the whole run.
    initial begin : run_watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= LIMIT_CYCLES) begin
                $display("%0t: timeout with %0d ranks outstanding", $time,
                         board.owed_ranks.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Main stimulus.
    initial begin : stimulus
        int sent;
        int set_no;
        int r;
        int len;
        bit marked;
        board       = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_key       = '0;
        s_final_key = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed sets.
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_key(dir_keys[i], dir_last[i], pick_gap());
        end

        // Random sets; the first two fill the chain, with and without the mark.
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS) begin
            if (set_no == 0) begin
                len    = N_CELLS;
                marked = 1'b0;
            end else if (set_no == 1) begin
                len    = N_CELLS;
                marked = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    len    = $urandom_range(1, 8);
                    marked = 1'b1;
                end else if (r < 80) begin
                    len    = $urandom_range(9, N_CELLS - 1);
                    marked = 1'b1;
                end else if (r < 87) begin
                    len    = N_CELLS;
                    marked = 1'b1;
                end else if (r < 94) begin
                    len    = N_CELLS;
                    marked = 1'b0;
                end else begin
                    // An unmarked fragment that runs on into the next set.
                    len    = $urandom_range(1, 4);
                    marked = 1'b0;
                end
            end
            send_random_set(len, marked, $urandom_range(0, 2), $urandom_range(0, 9) < 3);
            sent += len;
            set_no++;
        end
        s_valid <= 1'b0;

        // Wait for every owed rank, then watch for stray results.
        while (board.owed_ranks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (board.error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/sis_pkg.sv
hw/rtl/sis_cell.sv
hw/rtl/sis_chain.sv
hw/rtl/stable_index_insertion_sort.sv
test/tb_stable_index_insertion_sort.sv
